FILE: hw/rtl/floor_map_colour_blender_defines.svh
// ----------------------------------------------------------------------------
// Floor map colour blender assertion macros
// Shared assertion helpers. Defining ASSERT_OFF compiles them away.
// ----------------------------------------------------------------------------
`ifndef FLOOR_MAP_COLOUR_BLENDER_DEFINES_SVH
`define FLOOR_MAP_COLOUR_BLENDER_DEFINES_SVH
`ifndef ASSERT_OFF
`define FMCB_ASSERT(name, clk, rst_n, cond, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);
`define FMCB_ASSERT_IMP(name, clk, rst_n, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);
`else
`define FMCB_ASSERT(name, clk, rst_n, cond, msg)
`define FMCB_ASSERT_IMP(name, clk, rst_n, ante, cons, msg)
`endif
`endif

FILE: hw/rtl/fmcb_pkg.sv
// ----------------------------------------------------------------------------
// Floor map colour blender package
// Shared types, register map and constants.
// ----------------------------------------------------------------------------
package fmcb_pkg;

    localparam int DEF_GRID_SIDE   = 1024;
    localparam int DEF_QUEUE_DEPTH = 8;

    localparam logic [23:0] WEIGHT_RESET = 24'd6553600;

    // Register indexes (byte address divided by four).
    localparam logic [2:0] REG_POSE_X    = 3'd0;
    localparam logic [2:0] REG_POSE_Y    = 3'd1;
    localparam logic [2:0] REG_COS       = 3'd2;
    localparam logic [2:0] REG_SIN       = 3'd3;
    localparam logic [2:0] REG_GRID_MINX = 3'd4;
    localparam logic [2:0] REG_GRID_MINY = 3'd5;
    localparam logic [2:0] REG_CPM       = 3'd6;

    typedef struct packed {
        logic signed [23:0] pose_x;
        logic signed [23:0] pose_y;
        logic signed [15:0] cos_h;
        logic signed [15:0] sin_h;
        logic signed [23:0] grid_min_x;
        logic signed [23:0] grid_min_y;
        logic        [15:0] cpm;
    } t_cfg;

    typedef struct packed {
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
    } t_rgb;

endpackage

FILE: hw/rtl/floor_map_colour_blender.sv
// ----------------------------------------------------------------------------
// Floor map colour blender
// Projects floor pixels into a world grid and blends their colour into it.
// ----------------------------------------------------------------------------
// A pixel is handed in by raising start with the pixel fields; it is taken at
// a clock edge where start is high and busy is low. Each pixel produces
// exactly one result, shown for one cycle with o_valid high; the receiver
// cannot hold it off. The user must write pose, heading and grid registers
// through the APB port only while the block is idle; nothing enforces it.
// Path through the back end: a pixel off the floor returns once it is popped
// from the queue; a pixel landing in an empty cell or meeting a zero weight
// sum returns after its cell is read and checked; a blended cell returns
// after the one-bit-per-cycle divider forms 25 quotient bits for each of the
// three channels and for the new weight, and the cell is written back. The
// back end takes the next pixel only when the previous one has been written
// back, so it sustains one pixel per cycle off the floor while the queue holds
// pixels; a pixel that reads its cell holds later pixels in the queue.
// A five-stage address pipeline feeds an eight-entry queue so pixels can be
// accepted while the back end is still blending.
// After reset the back end sweeps all GRID_SIDE*GRID_SIDE cells of the
// cell store, one cell a cycle, with busy high.
// ----------------------------------------------------------------------------
`include "floor_map_colour_blender_defines.svh"

module floor_map_colour_blender #(
    parameter int GRID_SIDE   = fmcb_pkg::DEF_GRID_SIDE,
    parameter int QUEUE_DEPTH = fmcb_pkg::DEF_QUEUE_DEPTH
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        start,
    output logic        busy,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [4:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    input  logic [23:0] i_offset_x,
    input  logic [23:0] i_offset_y,
    input  logic [22:0] i_ray_length,
    input  logic [7:0]  i_pixel_red,
    input  logic [7:0]  i_pixel_green,
    input  logic [7:0]  i_pixel_blue,
    input  logic        i_on_floor,
    output logic        o_valid,
    output logic [9:0]  o_cell_column,
    output logic [9:0]  o_cell_row,
    output logic [7:0]  o_cell_red,
    output logic [7:0]  o_cell_green,
    output logic [7:0]  o_cell_blue,
    output logic        o_cell_written
);

    localparam int CW  = $clog2(GRID_SIDE);
    localparam int EW  = 1 + 2 * CW + 23 + 24;
    localparam int CNW = $clog2(QUEUE_DEPTH + 1);

    fmcb_pkg::t_cfg r_cfg;
    logic [CNW-1:0] r_count;
    logic           accept;
    logic           cfg_wr;
    logic           front_valid;
    logic [EW-1:0]  front_entry;
    logic           q_empty;
    logic [EW-1:0]  q_entry;
    logic           pop;
    logic           clearing;
    fmcb_pkg::t_rgb out_rgb;

    // Configuration registers. The write lands in the APB access phase.
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.pose_x     <= '0;
            r_cfg.pose_y     <= '0;
            r_cfg.cos_h      <= 16'sd16384;
            r_cfg.sin_h      <= '0;
            r_cfg.grid_min_x <= -24'sd655360;
            r_cfg.grid_min_y <= -24'sd655360;
            r_cfg.cpm        <= 16'd12800;
        end else if (cfg_wr) begin
            unique case (paddr[4:2])
                fmcb_pkg::REG_POSE_X:    r_cfg.pose_x     <= pwdata[23:0];
                fmcb_pkg::REG_POSE_Y:    r_cfg.pose_y     <= pwdata[23:0];
                fmcb_pkg::REG_COS:       r_cfg.cos_h      <= pwdata[15:0];
                fmcb_pkg::REG_SIN:       r_cfg.sin_h      <= pwdata[15:0];
                fmcb_pkg::REG_GRID_MINX: r_cfg.grid_min_x <= pwdata[23:0];
                fmcb_pkg::REG_GRID_MINY: r_cfg.grid_min_y <= pwdata[23:0];
                fmcb_pkg::REG_CPM:       r_cfg.cpm        <= pwdata[15:0];
                default:                 ;
            endcase
        end
    end

    always_comb begin
        unique case (paddr[4:2])
            fmcb_pkg::REG_POSE_X:    prdata = 32'(r_cfg.pose_x);
            fmcb_pkg::REG_POSE_Y:    prdata = 32'(r_cfg.pose_y);
            fmcb_pkg::REG_COS:       prdata = 32'(r_cfg.cos_h);
            fmcb_pkg::REG_SIN:       prdata = 32'(r_cfg.sin_h);
            fmcb_pkg::REG_GRID_MINX: prdata = 32'(r_cfg.grid_min_x);
            fmcb_pkg::REG_GRID_MINY: prdata = 32'(r_cfg.grid_min_y);
            fmcb_pkg::REG_CPM:       prdata = 32'(r_cfg.cpm);
            default:                 prdata = '0;
        endcase
    end

    // Credits: every pixel in the address pipeline or the queue holds one,
    // so the queue can never overflow even though the pipeline never stalls.
    assign busy   = clearing || (r_count == CNW'(QUEUE_DEPTH));
    assign accept = start && !busy;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
        end else begin
            r_count <= r_count + CNW'(accept) - CNW'(pop);
        end
    end

    fmcb_front #(.GRID_SIDE(GRID_SIDE), .CW(CW), .EW(EW)) u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (accept),
        .i_cfg        (r_cfg),
        .i_offset_x   (i_offset_x),
        .i_offset_y   (i_offset_y),
        .i_ray_length (i_ray_length),
        .i_rgb        ({i_pixel_red, i_pixel_green, i_pixel_blue}),
        .i_on_floor   (i_on_floor),
        .o_valid      (front_valid),
        .o_entry      (front_entry)
    );

    fmcb_queue #(.WIDTH(EW), .DEPTH(QUEUE_DEPTH)) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (front_valid),
        .i_data  (front_entry),
        .i_pop   (pop),
        .o_empty (q_empty),
        .o_data  (q_entry)
    );

    fmcb_back #(.GRID_SIDE(GRID_SIDE), .CW(CW), .EW(EW)) u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_empty    (q_empty),
        .i_entry    (q_entry),
        .o_pop      (pop),
        .o_clearing (clearing),
        .o_valid    (o_valid),
        .o_col      (o_cell_column),
        .o_row      (o_cell_row),
        .o_rgb      (out_rgb),
        .o_written  (o_cell_written)
    );

    assign o_cell_red   = out_rgb.red;
    assign o_cell_green = out_rgb.green;
    assign o_cell_blue  = out_rgb.blue;

    // The credit count never exceeds the queue size.
    `FMCB_ASSERT(a_credit_bound, i_clk, i_rst_n, r_count <= CNW'(QUEUE_DEPTH), "credit overflow")
    // The back end never pops an empty queue.
    `FMCB_ASSERT_IMP(a_pop_nonempty, i_clk, i_rst_n, pop, !q_empty, "pop from empty queue")
    // No result appears while the cell store is being cleared.
    `FMCB_ASSERT_IMP(a_no_out_clear, i_clk, i_rst_n, clearing, !o_valid, "result during clear")

endmodule

FILE: hw/rtl/fmcb_front.sv
// ----------------------------------------------------------------------------
// Floor map colour blender front end
// Five-stage pipeline from camera-frame offset to clamped grid cell.
// ----------------------------------------------------------------------------
module fmcb_front #(
    parameter int GRID_SIDE = fmcb_pkg::DEF_GRID_SIDE,
    parameter int CW        = $clog2(GRID_SIDE),
    parameter int EW        = 1 + 2 * CW + 23 + 24
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_valid,
    input  fmcb_pkg::t_cfg       i_cfg,
    input  logic signed [23:0]   i_offset_x,
    input  logic signed [23:0]   i_offset_y,
    input  logic [22:0]          i_ray_length,
    input  fmcb_pkg::t_rgb       i_rgb,
    input  logic                 i_on_floor,
    output logic                 o_valid,
    output logic [EW-1:0]        o_entry
);

    // Payload that rides along the pipeline.
    typedef struct packed {
        logic        on_floor;
        logic [22:0] d;
        logic [23:0] rgb;
    } t_side;

    logic [4:0] r_vld;
    t_side      r_side [5];

    logic signed [39:0] r_pxc, r_pys, r_pxs, r_pyc;
    logic signed [27:0] r_wx, r_wy;
    logic signed [28:0] r_dx, r_dy;
    logic signed [45:0] r_prx, r_pry;
    logic [CW-1:0]      r_col, r_row;

    logic signed [40:0] n_ax, n_ay;
    logic signed [40:0] n_ax_adj, n_ay_adj;
    logic signed [27:0] n_wx, n_wy;
    logic signed [21:0] n_cx, n_cy;
    logic [CW-1:0]      n_col, n_celly;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            r_vld <= {r_vld[3:0], i_valid};
        end
    end

    always_ff @(posedge i_clk) begin
        r_side[0] <= '{on_floor: i_on_floor, d: i_ray_length, rgb: i_rgb};
        for (int i = 1; i < 5; i++) begin
            r_side[i] <= r_side[i-1];
        end
    end

    // Rotation products.
    always_ff @(posedge i_clk) begin
        r_pxc <= i_cfg.cos_h * i_offset_x;
        r_pys <= i_cfg.sin_h * i_offset_y;
        r_pxs <= i_cfg.sin_h * i_offset_x;
        r_pyc <= i_cfg.cos_h * i_offset_y;
    end

    // Combine, divide by 2^14 toward zero, translate.
    always_comb begin
        n_ax     = 41'(r_pxc) - 41'(r_pys);
        n_ay     = 41'(r_pxs) + 41'(r_pyc);
        n_ax_adj = n_ax[40] ? n_ax + 41'sd16383 : n_ax;
        n_ay_adj = n_ay[40] ? n_ay + 41'sd16383 : n_ay;
        n_wx     = 28'(i_cfg.pose_x) + 28'(n_ax_adj >>> 14);
        n_wy     = 28'(i_cfg.pose_y) + 28'(n_ay_adj >>> 14);
    end

    always_ff @(posedge i_clk) begin
        r_wx  <= n_wx;
        r_wy  <= n_wy;
        r_dx  <= 29'(r_wx) - 29'(i_cfg.grid_min_x);
        r_dy  <= 29'(r_wy) - 29'(i_cfg.grid_min_y);
        r_prx <= r_dx * $signed({1'b0, i_cfg.cpm});
        r_pry <= r_dy * $signed({1'b0, i_cfg.cpm});
    end

    // Scale down by 2^24 and clamp to the grid. A negative product clamps
    // to zero, so floor and truncation agree here.
    always_comb begin
        n_cx = 22'(r_prx >>> 24);
        n_cy = 22'(r_pry >>> 24);
        if (n_cx < 0) begin
            n_col = '0;
        end else if (n_cx > 22'(GRID_SIDE - 1)) begin
            n_col = CW'(GRID_SIDE - 1);
        end else begin
            n_col = CW'(n_cx);
        end
        if (n_cy < 0) begin
            n_celly = '0;
        end else if (n_cy > 22'(GRID_SIDE - 1)) begin
            n_celly = CW'(GRID_SIDE - 1);
        end else begin
            n_celly = CW'(n_cy);
        end
    end

    always_ff @(posedge i_clk) begin
        r_col <= n_col;
        r_row <= CW'(GRID_SIDE - 1) - n_celly;
    end

    assign o_valid = r_vld[4];
    assign o_entry = {r_side[4].on_floor, r_col, r_row, r_side[4].d, r_side[4].rgb};

endmodule

FILE: hw/rtl/fmcb_queue.sv
// ----------------------------------------------------------------------------
// Floor map colour blender queue
// Small FIFO between the address front end and the cell update back end.
// ----------------------------------------------------------------------------
module fmcb_queue #(
    parameter int WIDTH = 8,
    parameter int DEPTH = fmcb_pkg::DEF_QUEUE_DEPTH,
    parameter int PW    = $clog2(DEPTH)
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  logic [WIDTH-1:0] i_data,
    input  logic             i_pop,
    output logic             o_empty,
    output logic [WIDTH-1:0] o_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [PW-1:0]    r_wr, r_rd;
    logic [PW:0]      r_cnt;

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wr <= (r_wr == PW'(DEPTH - 1)) ? '0 : r_wr + 1'b1;
            end
            if (i_pop) begin
                r_rd <= (r_rd == PW'(DEPTH - 1)) ? '0 : r_rd + 1'b1;
            end
            r_cnt <= r_cnt + (PW+1)'(i_push) - (PW+1)'(i_pop);
        end
    end

    assign o_empty = (r_cnt == '0);
    assign o_data  = r_mem[r_rd];

endmodule

FILE: hw/rtl/fmcb_div.sv
// ----------------------------------------------------------------------------
// Floor map colour blender divider
// Restoring divider, one quotient bit per cycle, 25 quotient bits.
// ----------------------------------------------------------------------------
module fmcb_div (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_start,
    input  logic [48:0] i_num,
    input  logic [24:0] i_den,
    output logic        o_done,
    output logic [24:0] o_quo
);

    // The caller guarantees num < den * 2^25, so the top bits start below den.
    logic [24:0] r_rem;
    logic [24:0] r_low;
    logic [24:0] r_quo;
    logic [24:0] r_den;
    logic [4:0]  r_cnt;
    logic        r_busy;
    logic        r_done;
    logic [25:0] n_trial;
    logic        n_ge;

    always_comb begin
        n_trial = {r_rem, r_low[24]};
        n_ge    = (n_trial >= {1'b0, r_den});
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= 5'd25;
            end else if (r_busy) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == 5'd1) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= {1'b0, i_num[48:25]};
            r_low <= i_num[24:0];
            r_den <= i_den;
        end else if (r_busy) begin
            r_rem <= n_ge ? 25'(n_trial - {1'b0, r_den}) : n_trial[24:0];
            r_low <= {r_low[23:0], 1'b0};
            r_quo <= {r_quo[23:0], n_ge};
        end
    end

    assign o_done = r_done;
    assign o_quo  = r_quo;

endmodule

FILE: hw/rtl/fmcb_back.sv
// ----------------------------------------------------------------------------
// Floor map colour blender back end
// Owns the cell store, clears it after reset and performs the blend.
// ----------------------------------------------------------------------------
module fmcb_back #(
    parameter int GRID_SIDE = fmcb_pkg::DEF_GRID_SIDE,
    parameter int CW        = $clog2(GRID_SIDE),
    parameter int EW        = 1 + 2 * CW + 23 + 24
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_empty,
    input  logic [EW-1:0]  i_entry,
    output logic           o_pop,
    output logic           o_clearing,
    output logic           o_valid,
    output logic [9:0]     o_col,
    output logic [9:0]     o_row,
    output fmcb_pkg::t_rgb o_rgb,
    output logic           o_written
);

    localparam int DEPTH = GRID_SIDE * GRID_SIDE;
    localparam int AW    = $clog2(DEPTH);

    localparam logic [2:0] ST_CLEAR = 3'd0;
    localparam logic [2:0] ST_IDLE  = 3'd1;
    localparam logic [2:0] ST_READ  = 3'd2;
    localparam logic [2:0] ST_CHECK = 3'd3;
    localparam logic [2:0] ST_MUL   = 3'd4;
    localparam logic [2:0] ST_DIV   = 3'd5;
    localparam logic [2:0] ST_WRITE = 3'd6;

    // Each word holds colour in the upper half and weight in the lower half.
    logic [47:0]    r_mem [DEPTH];
    logic [47:0]    r_rd;
    logic [2:0]     r_state, n_state;
    logic [AW-1:0]  r_clr;
    logic [EW-1:0]  r_ent;
    logic [1:0]     r_k;
    logic [23:0]    r_w, r_old, r_nc, r_nw;
    logic [24:0]    r_sum;
    logic [48:0]    r_num;
    logic           r_div_go;

    logic [CW-1:0]  ent_col, ent_row;
    logic [22:0]    ent_d;
    fmcb_pkg::t_rgb ent_rgb;
    logic [AW-1:0]  addr;
    logic [23:0]    rd_colour, rd_weight;
    logic [24:0]    sum;
    logic [7:0]     in_k, old_k;
    logic           mem_we;
    logic [AW-1:0]  mem_waddr;
    logic [47:0]    mem_wdata;
    logic           div_done;
    logic [24:0]    div_quo;

    // Only entries on the floor reach the states that use these fields.
    assign {ent_col, ent_row, ent_d, ent_rgb} = r_ent[EW-2:0];
    assign addr      = AW'(ent_row * GRID_SIDE) + AW'(ent_col);
    assign rd_colour = r_rd[47:24];
    assign rd_weight = r_rd[23:0];
    assign sum       = 25'(rd_weight) + 25'(ent_d);

    always_comb begin
        case (r_k)
            2'd0:    begin in_k = ent_rgb.red;   old_k = r_old[23:16]; end
            2'd1:    begin in_k = ent_rgb.green; old_k = r_old[15:8];  end
            default: begin in_k = ent_rgb.blue;  old_k = r_old[7:0];   end
        endcase
    end

    always_comb begin
        mem_we    = 1'b0;
        mem_waddr = addr;
        mem_wdata = {r_nc, r_nw};
        if (r_state == ST_CLEAR) begin
            mem_we    = 1'b1;
            mem_waddr = r_clr;
            mem_wdata = {24'd0, fmcb_pkg::WEIGHT_RESET};
        end else if (r_state == ST_CHECK && rd_colour == '0) begin
            mem_we    = 1'b1;
            mem_wdata = {ent_rgb, rd_weight};
        end else if (r_state == ST_WRITE) begin
            mem_we    = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[mem_waddr] <= mem_wdata;
        end
        if (r_state == ST_READ) begin
            r_rd <= r_mem[addr];
        end
    end

    assign o_pop = (r_state == ST_IDLE) && !i_empty;

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_CLEAR: if (r_clr == AW'(DEPTH - 1)) n_state = ST_IDLE;
            ST_IDLE:  if (!i_empty && i_entry[EW-1]) n_state = ST_READ;
            ST_READ:  n_state = ST_CHECK;
            ST_CHECK: if (rd_colour != '0 && sum != '0) n_state = ST_MUL;
                      else n_state = ST_IDLE;
            ST_MUL:   n_state = ST_DIV;
            ST_DIV:   if (div_done) n_state = (r_k == 2'd3) ? ST_WRITE : ST_MUL;
            ST_WRITE: n_state = ST_IDLE;
            default:  n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_CLEAR;
            r_clr    <= '0;
            r_div_go <= 1'b0;
            o_valid  <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_div_go <= (r_state == ST_MUL);
            o_valid  <= 1'b0;
            if (r_state == ST_CLEAR) begin
                r_clr <= r_clr + 1'b1;
            end
            if (o_pop && !i_entry[EW-1]) begin
                o_valid <= 1'b1;
            end
            if (r_state == ST_CHECK && (rd_colour == '0 || sum == '0)) begin
                o_valid <= 1'b1;
            end
            if (r_state == ST_WRITE) begin
                o_valid <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_ent <= i_entry;
            if (!i_entry[EW-1]) begin
                o_col     <= '0;
                o_row     <= '0;
                o_rgb     <= '0;
                o_written <= 1'b0;
            end
        end
        if (r_state == ST_CHECK) begin
            r_k   <= 2'd0;
            r_w   <= rd_weight;
            r_old <= rd_colour;
            r_sum <= sum;
            o_col <= 10'(ent_col);
            o_row <= 10'(ent_row);
            if (rd_colour == '0) begin
                o_rgb     <= ent_rgb;
                o_written <= 1'b1;
            end else begin
                o_rgb     <= rd_colour;
                o_written <= 1'b0;
            end
        end
        if (r_state == ST_MUL) begin
            if (r_k == 2'd3) begin
                r_num <= {1'b0, 47'(r_w * ent_d), 1'b0};
            end else begin
                r_num <= 49'(r_w * in_k) + 49'(ent_d * old_k);
            end
        end
        if (r_state == ST_DIV && div_done) begin
            case (r_k)
                2'd0:    r_nc[23:16] <= div_quo[7:0];
                2'd1:    r_nc[15:8]  <= div_quo[7:0];
                2'd2:    r_nc[7:0]   <= div_quo[7:0];
                default: r_nw        <= div_quo[23:0];
            endcase
            r_k <= r_k + 1'b1;
        end
        if (r_state == ST_WRITE) begin
            o_rgb     <= r_nc;
            o_written <= 1'b1;
        end
    end

    fmcb_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (r_div_go),
        .i_num   (r_num),
        .i_den   (r_sum),
        .o_done  (div_done),
        .o_quo   (div_quo)
    );

    assign o_clearing = (r_state == ST_CLEAR);

endmodule
